// File: design/lcdns_pkg.sv
// Package: shared types, codes and the init sequence table for the LCD nibble sequencer.
`timescale 1ns / 1ps
package lcdns_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_INIT   = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_EN_HIGH  = 2'd0,
    REG_EN_LOW   = 2'd1,
    REG_POWER_UP = 2'd2
  } reg_idx_t;

  localparam logic [7:0] RST_EN_HIGH  = 8'd2;
  localparam logic [7:0] RST_EN_LOW   = 8'd2;
  localparam logic [7:0] RST_POWER_UP = 8'd40;

  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  localparam logic [4:0] BYTE_LAST_STEP = 5'd3;
  localparam logic [4:0] INIT_LAST_STEP = 5'd28;

  // Work item handed from the front to the back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic [7:0] en_high;
    logic [7:0] en_low;
    logic [7:0] power_up;
  } cfg_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [7:0] extra;
  } init_seg_t;

  // Nibble and extra enable-low wait for init steps 1..28 (step 0 is the power-up wait).
  // Odd steps are enable-high, even steps enable-low; extra only applies on even steps.
  function automatic init_seg_t init_seg(logic [4:0] step);
    init_seg_t s;
    s = '{nibble: 4'h0, extra: 8'd0};
    case (step) inside
      5'd1, 5'd2, 5'd3, 5'd4: s = '{nibble: 4'h3, extra: 8'd5};
      5'd5, 5'd6:             s = '{nibble: 4'h3, extra: 8'd1};
      5'd7, 5'd8:             s = '{nibble: 4'h2, extra: 8'd0};
      5'd9, 5'd10:            s = '{nibble: 4'h2, extra: 8'd0};
      5'd11, 5'd12:           s = '{nibble: 4'h8, extra: 8'd0};
      5'd13, 5'd14:           s = '{nibble: 4'h0, extra: 8'd0};
      5'd15, 5'd16:           s = '{nibble: 4'h8, extra: 8'd0};
      5'd17, 5'd18:           s = '{nibble: 4'h0, extra: 8'd0};
      5'd19, 5'd20:           s = '{nibble: 4'h1, extra: 8'd2};
      5'd21, 5'd22:           s = '{nibble: 4'h0, extra: 8'd0};
      5'd23, 5'd24:           s = '{nibble: 4'h6, extra: 8'd0};
      5'd25, 5'd26:           s = '{nibble: 4'h0, extra: 8'd0};
      5'd27, 5'd28:           s = '{nibble: 4'hC, extra: 8'd0};
      default:                s = '{nibble: 4'h0, extra: 8'd0};
    endcase
    return s;
  endfunction

endpackage

// File: design/lcdns_if.sv
// Interfaces: request channel and pin-segment channel.
`timescale 1ns / 1ps
interface lcdns_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       row;
  logic [5:0] col;

  modport source (output valid, kind, byte_value, row, col, input ready);
  modport sink   (input valid, kind, byte_value, row, col, output ready);
endinterface

interface lcdns_out_if;
  logic       valid;
  logic       ready;
  logic       rs;
  logic       en;
  logic [3:0] nibble;
  logic [7:0] hold_ms;
  logic       last;

  modport source (output valid, rs, en, nibble, hold_ms, last, input ready);
  modport sink   (input valid, rs, en, nibble, hold_ms, last, output ready);
endinterface

// File: design/lcdns_front.sv
// Front end: accept requests and classify them into byte or init jobs.
`timescale 1ns / 1ps
module lcdns_front import lcdns_pkg::*; (
  lcdns_in_if.sink in_ch,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  kind_t      kind;
  logic [7:0] cursor_addr;

  assign kind        = kind_t'(in_ch.kind);
  assign cursor_addr = (in_ch.row ? ROW1_BASE : ROW0_BASE) + {2'b00, in_ch.col};

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_job = '{is_init: 1'b0, rs: 1'b0, data: in_ch.byte_value};
    case (kind)
      KIND_CMD:    push_job = '{is_init: 1'b0, rs: 1'b0, data: in_ch.byte_value};
      KIND_DATA:   push_job = '{is_init: 1'b0, rs: 1'b1, data: in_ch.byte_value};
      KIND_INIT:   push_job = '{is_init: 1'b1, rs: 1'b0, data: 8'h00};
      KIND_CURSOR: push_job = '{is_init: 1'b0, rs: 1'b0, data: cursor_addr};
      default:     push_job = '{is_init: 1'b0, rs: 1'b0, data: in_ch.byte_value};
    endcase
  end

endmodule

// File: design/lcdns_queue.sv
// Job queue: small FIFO between the front end and the sequencer.
`timescale 1ns / 1ps
module lcdns_queue import lcdns_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == FULL_CNT);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/lcdns_back.sv
// Back end: step through the pin segments of one job and register each result.
`timescale 1ns / 1ps
module lcdns_back import lcdns_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  job_t  q_job,
  output logic  pop,
  lcdns_out_if.source out_ch
);

  logic       busy_r, busy_nxt;
  job_t       job_r;
  logic [4:0] step_r, step_nxt;
  logic       rs_level_r;
  logic [3:0] nib_level_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_rs_r, out_en_r, out_last_r;
  logic [3:0] out_nib_r;
  logic [7:0] out_hold_r;

  logic       emit;
  logic       seg_rs, seg_en, seg_last;
  logic [3:0] seg_nib;
  logic [7:0] seg_hold;
  logic [7:0] low_extra;
  logic [8:0] low_sum;
  init_seg_t  iseg;

  assign emit = busy_r && (!out_valid_r || out_ch.ready);
  assign pop  = q_valid && (!busy_r || (emit && seg_last));
  assign iseg = init_seg(step_r);

  // Saturating enable-low hold
  assign low_extra = job_r.is_init ? iseg.extra : 8'd0;
  assign low_sum   = {1'b0, cfg.en_low} + {1'b0, low_extra};

  always_comb begin
    if (job_r.is_init) begin
      seg_last = (step_r == INIT_LAST_STEP);
      if (step_r == '0) begin
        seg_rs   = rs_level_r;
        seg_en   = 1'b0;
        seg_nib  = nib_level_r;
        seg_hold = cfg.power_up;
      end else begin
        seg_rs   = 1'b0;
        seg_en   = step_r[0];
        seg_nib  = iseg.nibble;
        seg_hold = seg_en ? cfg.en_high : (low_sum[8] ? 8'hFF : low_sum[7:0]);
      end
    end else begin
      seg_last = (step_r == BYTE_LAST_STEP);
      seg_rs   = job_r.rs;
      seg_en   = !step_r[0];
      seg_nib  = step_r[1] ? job_r.data[3:0] : job_r.data[7:4];
      seg_hold = seg_en ? cfg.en_high : cfg.en_low;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (emit) begin
      step_nxt = seg_last ? '0 : step_r + 1'b1;
      if (seg_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      rs_level_r  <= 1'b0;
      nib_level_r <= 4'h0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        rs_level_r  <= seg_rs;
        nib_level_r <= seg_nib;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_rs_r   <= seg_rs;
      out_en_r   <= seg_en;
      out_nib_r  <= seg_nib;
      out_hold_r <= seg_hold;
      out_last_r <= seg_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.rs      = out_rs_r;
  assign out_ch.en      = out_en_r;
  assign out_ch.nibble  = out_nib_r;
  assign out_ch.hold_ms = out_hold_r;
  assign out_ch.last    = out_last_r;

`ifndef NO_ASSERTIONS
  // Step counter stays inside the job's segment range
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.is_init ? (step_r <= INIT_LAST_STEP) : (step_r <= BYTE_LAST_STEP)))
    else $error("lcdns_back: step out of range");

  // Sequencer goes idle after the last segment when no job is waiting
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && seg_last && !q_valid |=> !busy_r)
    else $error("lcdns_back: still busy after last segment");

  // A byte job leaves the register-select level it asked for
  a_rs_level: assert property (@(posedge clk) disable iff (!rst_n)
    emit && seg_last && !job_r.is_init |=> rs_level_r == $past(job_r.rs))
    else $error("lcdns_back: rs level mismatch after byte");
`endif

endmodule

// File: design/char_lcd_nibble_sequencer_unit.sv
// Top level: character LCD 4-bit bus sequencer with register port.
`timescale 1ns / 1ps
// The job queue and the back-end job register lie between a request's transfer and out_ch.
// Throughput: one segment per cycle while out_ch is ready; command, data and cursor
//   requests give 4 segments and init gives 29, set by the back-end segment counter.
// A two-entry job queue lets new requests transfer while a request is being sequenced.
// Reset (synchronous, rst_n low): registers return to 2/2/40 ms, pin levels to 0,
//   the queue empties and no segment is pending.
module char_lcd_nibble_sequencer_unit import lcdns_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  lcdns_in_if.sink          in_ch,
  lcdns_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic q_full, q_valid, push, pop;
  job_t push_job, q_job;

  // Register port: zero wait states, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{en_high: RST_EN_HIGH, en_low: RST_EN_LOW, power_up: RST_POWER_UP};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_EN_HIGH:  cfg_r.en_high  <= pwdata[7:0];
        REG_EN_LOW:   cfg_r.en_low   <= pwdata[7:0];
        REG_POWER_UP: cfg_r.power_up <= pwdata[7:0];
        default:      cfg_r <= cfg_r; // unmapped slot: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EN_HIGH:  prdata = {24'd0, cfg_r.en_high};
      REG_EN_LOW:   prdata = {24'd0, cfg_r.en_low};
      REG_POWER_UP: prdata = {24'd0, cfg_r.power_up};
      default:      prdata = '0;
    endcase
  end

  // Front: classify the request and build the byte to send
  lcdns_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple request intake from the slow segment sequencing
  lcdns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  // Back: hold the pin levels and emit one segment per transfer
  lcdns_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: test/testbench.sv
// Testbench: checks the LCD nibble sequencer's pin segments against a scoreboard predictor.
`timescale 1ns / 1ps

typedef struct packed {
  logic       rs;
  logic       en;
  logic [3:0] nibble;
  logic [7:0] hold_ms;
  logic       last;
} pin_seg_t;

// Predicts the pin segments of every accepted request and checks what comes out.
class lcd_segment_book;
  localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
  localparam logic [7:0] FUNCTION_SET    = 8'h28;
  localparam logic [7:0] DISPLAY_OFF     = 8'h08;
  localparam logic [7:0] CLEAR_DISPLAY   = 8'h01;
  localparam logic [7:0] ENTRY_MODE      = 8'h06;
  localparam logic [7:0] DISPLAY_ON      = 8'h0C;

  pin_seg_t   awaited[$];
  logic [7:0] en_high_ms;
  logic [7:0] en_low_ms;
  logic [7:0] power_up_ms;
  logic       rs_now;
  logic [3:0] nibble_now;
  int         errors;
  int         requests;
  int         inits;
  int         segments;

  function new();
    en_high_ms  = lcdns_pkg::RST_EN_HIGH;
    en_low_ms   = lcdns_pkg::RST_EN_LOW;
    power_up_ms = lcdns_pkg::RST_POWER_UP;
    rs_now      = 1'b0;
    nibble_now  = 4'h0;
    errors      = 0;
    requests    = 0;
    inits       = 0;
    segments    = 0;
  endfunction

  function void set_register(lcdns_pkg::reg_idx_t idx, logic [7:0] value);
    case (idx)
      lcdns_pkg::REG_EN_HIGH:  en_high_ms = value;
      lcdns_pkg::REG_EN_LOW:   en_low_ms = value;
      lcdns_pkg::REG_POWER_UP: power_up_ms = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void push_segment(logic en, logic [7:0] hold);
    awaited.push_back('{rs: rs_now, en: en, nibble: nibble_now, hold_ms: hold, last: 1'b0});
  endfunction

  // One nibble: enable high, then enable low with the extra wait, saturating at 255.
  function void push_nibble(logic [3:0] nib, logic [7:0] extra);
    logic [8:0] low_sum;
    nibble_now = nib;
    push_segment(1'b1, en_high_ms);
    low_sum = {1'b0, en_low_ms} + {1'b0, extra};
    push_segment(1'b0, low_sum[8] ? 8'hFF : low_sum[7:0]);
  endfunction

  function void push_byte(logic rs, logic [7:0] value, logic [7:0] extra);
    rs_now = rs;
    push_nibble(value[7:4], 8'd0);
    push_nibble(value[3:0], extra);
  endfunction

  function void note_request(lcdns_pkg::kind_t kind, logic [7:0] value, logic row,
                             logic [5:0] col);
    requests++;
    case (kind)
      lcdns_pkg::KIND_CMD:    push_byte(1'b0, value, 8'd0);
      lcdns_pkg::KIND_DATA:   push_byte(1'b1, value, 8'd0);
      lcdns_pkg::KIND_CURSOR:
        push_byte(1'b0, (row ? lcdns_pkg::ROW1_BASE : lcdns_pkg::ROW0_BASE) + {2'b00, col},
                  8'd0);
      default: begin
        inits++;
        // Power-up wait keeps whatever levels the pins already have
        push_segment(1'b0, power_up_ms);
        rs_now = 1'b0;
        push_nibble(WAKE_NIBBLE, 8'd5);
        push_nibble(WAKE_NIBBLE, 8'd5);
        push_nibble(WAKE_NIBBLE, 8'd1);
        push_nibble(FOUR_BIT_NIBBLE, 8'd0);
        push_byte(1'b0, FUNCTION_SET, 8'd0);
        push_byte(1'b0, DISPLAY_OFF, 8'd0);
        push_byte(1'b0, CLEAR_DISPLAY, 8'd2);
        push_byte(1'b0, ENTRY_MODE, 8'd0);
        push_byte(1'b0, DISPLAY_ON, 8'd0);
      end
    endcase
    awaited[awaited.size() - 1].last = 1'b1;
  endfunction

  function void check_segment(logic rs, logic en, logic [3:0] nibble, logic [7:0] hold,
                              logic last);
    pin_seg_t want;
    if (awaited.size() == 0) begin
      $error("pin segment rs=%0b en=%0b nibble=%h hold=%0d last=%0b with none outstanding",
             rs, en, nibble, hold, last);
      errors++;
      return;
    end
    want = awaited.pop_front();
    segments++;
    if (rs !== want.rs) begin
      $error("rs: expected %0b, got %0b", want.rs, rs);
      errors++;
    end
    if (en !== want.en) begin
      $error("en: expected %0b, got %0b", want.en, en);
      errors++;
    end
    if (nibble !== want.nibble) begin
      $error("nibble: expected %h, got %h", want.nibble, nibble);
      errors++;
    end
    if (hold !== want.hold_ms) begin
      $error("hold_ms: expected %0d, got %0d", want.hold_ms, hold);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import lcdns_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  // High while neither side idles
  logic              steady;
  int                settings;

  lcdns_in_if  in_ch();
  lcdns_out_if out_ch();

  lcd_segment_book book = new();

  char_lcd_nibble_sequencer_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Stall the segment channel at random, about 16 percent of the time, never while steady.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Check every pin segment transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      book.check_segment(out_ch.rs, out_ch.en, out_ch.nibble, out_ch.hold_ms, out_ch.last);
    end
  end

  // Hard stop: far beyond the slowest correct run (248 inits with long stalls on every segment).
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Every task starts just after a falling edge with nothing yet driven in that step
  // and returns at a later falling edge.

  // Drive one request; idle at random first, hold it until the transfer.
  task automatic send_request(kind_t kind, logic [7:0] value, logic row, logic [5:0] col);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.byte_value <= value;
    in_ch.row        <= row;
    in_ch.col        <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.note_request(kind, value, row, col);
    @(negedge clk);
  endtask

  // Random request; the fields a kind ignores are random too.
  task automatic random_request();
    int   pick;
    kind_t kind;
    pick = $urandom_range(0, 9);
    if (pick < 3) kind = KIND_CMD;
    else if (pick < 6) kind = KIND_DATA;
    else if (pick < 7) kind = KIND_INIT;
    else kind = KIND_CURSOR;
    send_request(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 6'(kind == KIND_CURSOR ? $urandom_range(0, 39) : $urandom_range(0, 63)));
  endtask

  // Drop valid and wait until every predicted segment has come out, then let the pipe settle.
  task automatic drain_segments();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle held until pready.
  task automatic write_register(reg_idx_t idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] high_ms;
    logic [7:0] low_ms;
    logic [7:0] wake_ms;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_CMD;
    in_ch.byte_value = 8'd0;
    in_ch.row        = 1'b0;
    in_ch.col        = 6'd0;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    steady           = 1'b0;
    settings         = 1;
    rst_n            = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset register values.
    // Init straight after reset: power-up wait shows all-zero levels.
    send_request(KIND_INIT, 8'h5A, 1'b1, 6'd63);
    send_request(KIND_CMD, 8'h00, 1'b1, 6'd63);
    send_request(KIND_CMD, 8'hFF, 1'b0, 6'd0);
    send_request(KIND_DATA, 8'hA5, 1'b0, 6'd21);
    send_request(KIND_DATA, 8'h5A, 1'b1, 6'd42);
    send_request(KIND_DATA, 8'hFF, 1'b0, 6'd0);
    // Init after a data byte: power-up wait keeps rs high and the last nibble.
    send_request(KIND_INIT, 8'hFF, 1'b0, 6'd0);
    send_request(KIND_CURSOR, 8'hFF, 1'b0, 6'd0);
    send_request(KIND_CURSOR, 8'h00, 1'b0, 6'd39);
    send_request(KIND_CURSOR, 8'hA5, 1'b1, 6'd0);
    send_request(KIND_CURSOR, 8'h5A, 1'b1, 6'd39);
    // Column beyond the display; row 1 base plus 63 still fits in a byte.
    send_request(KIND_CURSOR, 8'h3C, 1'b1, 6'd63);
    send_request(KIND_CMD, 8'h01, 1'b0, 6'd21);
    send_request(KIND_DATA, 8'h00, 1'b1, 6'd63);
    send_request(KIND_CMD, 8'h80, 1'b1, 6'd8);
    send_request(KIND_DATA, 8'h7E, 1'b0, 6'd16);

    // Register settings: extremes first (saturating waits, zero holds), then random ones.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin high_ms = 8'd255; low_ms = 8'd255; wake_ms = 8'd0;   end
        1: begin high_ms = 8'd1;   low_ms = 8'd1;   wake_ms = 8'd255; end
        2: begin high_ms = 8'd0;   low_ms = 8'd200; wake_ms = 8'd1;   end
        3: begin high_ms = 8'd254; low_ms = 8'd251; wake_ms = 8'd128; end
        default: begin
          high_ms = 8'($urandom_range(1, 255));
          low_ms  = 8'($urandom_range(1, 200));
          wake_ms = 8'($urandom_range(0, 255));
        end
      endcase
      drain_segments();
      write_register(REG_EN_HIGH, high_ms);
      write_register(REG_EN_LOW, low_ms);
      write_register(REG_POWER_UP, wake_ms);
      settings++;
      // One whole phase runs back to back on both channels.
      steady = (phase == 3);
      send_request(KIND_INIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   6'($urandom_range(0, 63)));
      for (int n = 0; n < 40; n++) begin
        // Hold off once mid-phase until the block has emptied.
        if (phase == 0 && n == 20) drain_segments();
        random_request();
      end
      steady = 1'b0;
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (book.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d requests (%0d of them init) across %0d register settings.",
             book.requests, book.inits, settings);
    $display("Checked %0d pin segments with %0d mismatches.", book.segments, book.errors);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/lcdns_pkg.sv
design/lcdns_if.sv
design/lcdns_front.sv
design/lcdns_queue.sv
design/lcdns_back.sv
design/char_lcd_nibble_sequencer_unit.sv
test/testbench.sv
